>>> hw/rtl/wsp_pkg.sv
package wsp_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_W = 48;
  localparam int MAG_W = 48;
  localparam int PROD_W = 80;
  localparam int TOTAL_W = 50;
  localparam int PQ_W = TOTAL_W - 16;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_DT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_PER_DT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_LIMIT = 3'd5;

  localparam logic [31:0] RST_TARGET_SPEED = 32'd6553600;
  localparam logic [31:0] RST_SPEED_SCALE = 32'd65536;
  localparam logic [31:0] RST_GAIN_P = 32'd655360;
  localparam logic [31:0] RST_GAIN_I_DT = 32'd2147484;
  localparam logic [31:0] RST_GAIN_D_PER_DT = 32'd0;
  localparam logic [14:0] RST_PWM_LIMIT = 15'd300;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [47:0] S48_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] S48_MIN = 48'h8000_0000_0000;

  // magnitude caps for the saturated products, negative side one larger
  localparam logic [MAG_W-1:0] CAP_SPD_POS = 48'h0000_7FFF_FFFF;
  localparam logic [MAG_W-1:0] CAP_SPD_NEG = 48'h0000_8000_0000;
  localparam logic [MAG_W-1:0] CAP_TERM_POS = 48'h7FFF_FFFF_FFFF;
  localparam logic [MAG_W-1:0] CAP_TERM_NEG = 48'h8000_0000_0000;

  typedef struct packed {
    logic [31:0] target_speed;
    logic [31:0] speed_scale;
    logic [31:0] gain_p;
    logic [31:0] gain_i_dt;
    logic [31:0] gain_d_per_dt;
    logic [14:0] pwm_limit;
  } wsp_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_ACC,
    ST_MUL_SAT,
    ST_MUL_SIGN,
    ST_ERR,
    ST_INT,
    ST_PWM_TRUNC,
    ST_PWM_CLAMP,
    ST_DONE
  } wsp_state_t;

  typedef enum logic [1:0] {
    OP_SPD,
    OP_P,
    OP_I,
    OP_D
  } wsp_op_t;

endpackage

>>> hw/rtl/wheel_speed_pid_controller.sv
// Wheel speed PID controller. Each input item carries the left and right encoder
// count changes of one control tick; the block returns one item with the clamped
// pwm drive value and the measured speed (signed Q16.16 cm/s). One 32x32 multiplier
// is shared by four products (speed, P, I and D terms), each taking two passes over
// it, so the core finishes one item before it takes the next. s_axis_tready is low
// while an item is in work; a finished result waits in the output register, so the
// next item can start before it is taken. Configuration writes are always accepted
// and must only be issued while the block has no item in flight. The integral and
// previous error are cleared by rst.
module wheel_speed_pid_controller #(
  parameter int COUNT_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // left_count [COUNT_BITS-1:0], right_count above it, zero padding to bytes
  input  logic [((2*COUNT_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // pwm_value [15:0], measured_speed [47:16]
  output logic [wsp_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [wsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wsp_pkg::*;

  wsp_cfg_t    cfg;
  logic        res_valid;
  logic        res_ready;
  logic [15:0] pwm_value;
  logic [31:0] measured_speed;

  wsp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wsp_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .left_count     (s_axis_tdata[COUNT_BITS-1:0]),
    .right_count    (s_axis_tdata[2*COUNT_BITS-1:COUNT_BITS]),
    .cfg            (cfg),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .pwm_value      (pwm_value),
    .measured_speed (measured_speed)
  );

  // load the output register when it is empty or being drained
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {measured_speed, pwm_value};
    end
  end

endmodule

>>> hw/rtl/wsp_mul.sv
module wsp_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> hw/rtl/wsp_cfg.sv
module wsp_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wsp_pkg::CFG_DATA_W-1:0]      cfg_data,
  output wsp_pkg::wsp_cfg_t                   cfg
);
  import wsp_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_speed <= RST_TARGET_SPEED;
      cfg.speed_scale <= RST_SPEED_SCALE;
      cfg.gain_p <= RST_GAIN_P;
      cfg.gain_i_dt <= RST_GAIN_I_DT;
      cfg.gain_d_per_dt <= RST_GAIN_D_PER_DT;
      cfg.pwm_limit <= RST_PWM_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_SPEED: cfg.target_speed <= cfg_data;
        REG_SPEED_SCALE: cfg.speed_scale <= cfg_data;
        REG_GAIN_P: cfg.gain_p <= cfg_data;
        REG_GAIN_I_DT: cfg.gain_i_dt <= cfg_data;
        REG_GAIN_D_PER_DT: cfg.gain_d_per_dt <= cfg_data;
        REG_PWM_LIMIT: cfg.pwm_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/wsp_core.sv
module wsp_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COUNT_BITS-1:0] left_count,
  input  logic [COUNT_BITS-1:0] right_count,
  input  wsp_pkg::wsp_cfg_t     cfg,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [15:0]           pwm_value,
  output logic [31:0]           measured_speed
);
  import wsp_pkg::*;

  localparam int SUM_W = COUNT_BITS + 1;

  wsp_state_t state, state_next;

  wsp_op_t            op;
  logic               neg;
  logic [MAG_W-1:0]   mag;
  logic [31:0]        gain;
  logic [63:0]        lo;
  logic [PROD_W-1:0]  prod;
  logic [MAG_W-1:0]   qs;
  logic [31:0]        speed;
  logic [31:0]        err;
  logic [47:0]        error_sum;
  logic [31:0]        last_error;
  logic [32:0]        diff;
  logic [TOTAL_W-1:0] total;
  logic [PQ_W-1:0]    pq;
  logic [15:0]        pwm;

  logic [31:0] mul_a;
  logic [63:0] mul_p;

  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   sum_mag;
  logic [PROD_W-1:0]  q;
  logic               rem;
  logic [PROD_W-1:0]  q_inc;
  logic [MAG_W-1:0]   cap;
  logic [MAG_W-1:0]   qs_next;
  logic [31:0]        speed_next;
  logic [TOTAL_W-1:0] total_next;
  logic [32:0]        e33;
  logic [31:0]        err_sat;
  logic [48:0]        es49;
  logic [47:0]        es_sat;
  logic [32:0]        diff_next;
  logic [31:0]        err_mag;
  logic [47:0]        es_mag;
  logic [32:0]        diff_mag;
  logic [PQ_W-1:0]    pq_next;
  logic [PQ_W-1:0]    lim;
  logic [PQ_W-1:0]    lim_neg;
  logic [15:0]        pwm_next;

  wsp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (gain),
    .p   (mul_p)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_MUL_ACC;
      ST_MUL_ACC: state_next = ST_MUL_SAT;
      ST_MUL_SAT: state_next = ST_MUL_SIGN;
      ST_MUL_SIGN: begin
        case (op)
          OP_SPD: state_next = ST_ERR;
          OP_D: state_next = ST_PWM_TRUNC;
          default: state_next = ST_MUL_LO;
        endcase
      end
      ST_ERR: state_next = ST_INT;
      ST_INT: state_next = ST_MUL_LO;
      ST_PWM_TRUNC: state_next = ST_PWM_CLAMP;
      ST_PWM_CLAMP: state_next = ST_DONE;
      ST_DONE: if (res_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    res_valid = (state == ST_DONE);
    mul_a = (state == ST_MUL_HI) ? {16'd0, mag[47:32]} : mag[31:0];
  end

  // count sum and its magnitude
  always_comb begin
    sum = {left_count[COUNT_BITS-1], left_count} + {right_count[COUNT_BITS-1], right_count};
    sum_mag = sum[SUM_W-1] ? SUM_W'(~sum + SUM_W'(1)) : sum;
  end

  // scale and saturate the product magnitude; negative side rounds toward minus infinity
  always_comb begin
    case (op)
      OP_SPD: begin
        q = prod;
        rem = 1'b0;
      end
      OP_I: begin
        q = prod >> 32;
        rem = |prod[31:0];
      end
      default: begin
        q = prod >> 16;
        rem = |prod[15:0];
      end
    endcase
    if (op == OP_SPD) cap = neg ? CAP_SPD_NEG : CAP_SPD_POS;
    else cap = neg ? CAP_TERM_NEG : CAP_TERM_POS;
    q_inc = q + PROD_W'(neg && rem);
    qs_next = (q_inc > {32'd0, cap}) ? cap : q_inc[MAG_W-1:0];
    speed_next = neg ? 32'(~qs[31:0] + 32'd1) : qs[31:0];
    total_next = total + (neg ? ~{2'b00, qs} : {2'b00, qs}) + TOTAL_W'(neg);
  end

  always_comb begin
    e33 = {cfg.target_speed[31], cfg.target_speed} - {speed[31], speed};
    if (e33[32] != e33[31]) err_sat = e33[32] ? S32_MIN : S32_MAX;
    else err_sat = e33[31:0];
    es49 = {error_sum[47], error_sum} + {{17{err[31]}}, err};
    if (es49[48] != es49[47]) es_sat = es49[48] ? S48_MIN : S48_MAX;
    else es_sat = es49[47:0];
    diff_next = {err[31], err} - {last_error[31], last_error};
    err_mag = err[31] ? 32'(~err + 32'd1) : err;
    es_mag = error_sum[47] ? 48'(~error_sum + 48'd1) : error_sum;
    diff_mag = diff[32] ? 33'(~diff + 33'd1) : diff;
  end

  // truncate toward zero, then clamp
  always_comb begin
    pq_next = total[TOTAL_W-1:16] + PQ_W'(total[TOTAL_W-1] && (|total[15:0]));
    lim = {{(PQ_W-15){1'b0}}, cfg.pwm_limit};
    lim_neg = PQ_W'(~lim + PQ_W'(1));
    if ($signed(pq) > $signed(lim)) pwm_next = lim[15:0];
    else if ($signed(pq) < $signed(lim_neg)) pwm_next = lim_neg[15:0];
    else pwm_next = pq[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      error_sum <= '0;
      last_error <= '0;
    end else begin
      state <= state_next;
      if (state == ST_INT) begin
        error_sum <= es_sat;
        last_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op <= OP_SPD;
          neg <= sum[SUM_W-1];
          mag <= MAG_W'(sum_mag);
          gain <= cfg.speed_scale;
        end
      end
      ST_MUL_HI: lo <= mul_p;
      ST_MUL_ACC: prod <= {16'd0, lo} + {mul_p[47:0], 32'd0};
      ST_MUL_SAT: qs <= qs_next;
      ST_MUL_SIGN: begin
        if (op == OP_SPD) speed <= speed_next;
        else total <= total_next;
        case (op)
          OP_P: begin
            op <= OP_I;
            neg <= error_sum[47];
            mag <= es_mag;
            gain <= cfg.gain_i_dt;
          end
          OP_I: begin
            op <= OP_D;
            neg <= diff[32];
            mag <= MAG_W'(diff_mag);
            gain <= cfg.gain_d_per_dt;
          end
          default: ;
        endcase
      end
      ST_ERR: err <= err_sat;
      ST_INT: begin
        diff <= diff_next;
        total <= '0;
        op <= OP_P;
        neg <= err[31];
        mag <= MAG_W'(err_mag);
        gain <= cfg.gain_p;
      end
      ST_PWM_TRUNC: pq <= pq_next;
      ST_PWM_CLAMP: pwm <= pwm_next;
      default: ;
    endcase
  end

  assign pwm_value = pwm;
  assign measured_speed = speed;

endmodule

>>> hw/rtl/wsp_check.sv
module wsp_check (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [wsp_pkg::OUT_W-1:0] m_axis_tdata,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic [wsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [wsp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wsp_pkg::*;

  logic        in_acc;
  logic        out_acc;
  logic [1:0]  pending;
  logic [14:0] lim;
  logic [15:0] lim16;
  logic [15:0] pwm;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign lim16 = {1'b0, lim};
  assign pwm = m_axis_tdata[15:0];

  // track items in flight and the current clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      lim <= RST_PWM_LIMIT;
    end else begin
      if (in_acc && !out_acc) pending <= pending + 2'd1;
      else if (!in_acc && out_acc) pending <= pending - 2'd1;
      if (cfg_valid && cfg_ready && cfg_index == REG_PWM_LIMIT) lim <= cfg_data[14:0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 2'd0)
    else $error("output item without an accepted input item");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two items in flight");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_axis_tready)
    else $error("input taken again right after an accepted item");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(pwm) <= $signed(lim16)) && ($signed(pwm) >= -$signed(lim16)))
    else $error("pwm value outside the configured limit");

endmodule

bind wheel_speed_pid_controller wsp_check u_wsp_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready),
  .cfg_index     (cfg_index),
  .cfg_data      (cfg_data)
);
